[src/rtit_pkg.sv]
// shared types and constants for the ranked insert table
package rtit_pkg;

    localparam int DEF_TABLE_DEPTH = 8;
    localparam int SCORE_W         = 32;
    localparam int SECS_W          = 16;
    localparam int TAG_W           = 32;
    localparam int SLOT_W          = 3;
    localparam int OP_W            = 2;
    localparam int IN_DATA_W       = 88;
    localparam int OUT_DATA_W      = 88;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef struct packed {
        logic [TAG_W-1:0]          tag;
        logic [SECS_W-1:0]         secs;
        logic signed [SCORE_W-1:0] score;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        t_rec              entry;
        logic [SLOT_W-1:0] place_slot;
        logic              placed;
    } t_res;

endpackage

[src/ranked_topn_insert_table.sv]
// top level of the ranked top-n insert table with stream ports
//
// Keeps the TABLE_DEPTH best records (score, time, tag) in one table memory,
// ranked by higher score first and, on equal score, shorter time. Every request
// gives exactly one result. Opcode 0 inserts: the record goes into the first
// slot that is empty (time zero), holds a lower score, or holds the same score
// with a longer time; the entries below move down one place and the last drops
// out; the result tuser flag says whether it placed and tdata carries the slot.
// Opcode 1 clears the table, opcode 2 reads one slot (zeros beyond the table or
// for an empty slot), opcode 3 does nothing; unused result fields are zero.
// The table is empty after reset with no clearing pass. An insert holds the
// sequencer while it visits one table entry a cycle through the memory's one
// read port and one write port (read slot i+1 while slot i is written back).
// One request is worked at a time, and a new request is taken while the
// previous result still sits in the output register.
module ranked_topn_insert_table #(
    parameter int TABLE_DEPTH = rtit_pkg::DEF_TABLE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // new_score[31:0], new_time[47:32], new_tag[79:48], read_slot[82:80], zero pad
    input  logic [rtit_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // opcode[1:0]
    input  logic [rtit_pkg::OP_W-1:0]         s_axis_tuser,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // place_slot[2:0], entry_score[34:3], entry_time[50:35], entry_tag[82:51], zero pad
    output logic [rtit_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // placed[0]
    output logic                              m_axis_tuser
);
    import rtit_pkg::*;

    t_rec              req_rec;
    t_op               req_op;
    logic [SLOT_W-1:0] req_slot;

    logic res_valid;
    logic res_ready;
    t_res res;

    // output register: parts the sequencer from a stalled result consumer
    logic r_m_valid;
    t_res r_m_res;

    // unpack the request fields, lowest field first
    assign req_rec.score = s_axis_tdata[31:0];
    assign req_rec.secs  = s_axis_tdata[47:32];
    assign req_rec.tag   = s_axis_tdata[79:48];
    assign req_slot      = s_axis_tdata[82:80];
    assign req_op        = t_op'(s_axis_tuser);

    rtit_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_op        (req_op),
        .i_rec       (req_rec),
        .i_read_slot (req_slot),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // result register is free when empty or draining this cycle
    assign res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_m_res <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_res.placed;
    assign m_axis_tdata  = {5'b0, r_m_res.entry.tag, r_m_res.entry.secs,
                            r_m_res.entry.score, r_m_res.place_slot};

endmodule

[src/rtit_ram.sv]
// generic simple dual-port ram with registered read
module rtit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/rtit_engine.sv]
// table sequencer: scan, carry-shift insert, read and clear over the table ram
module rtit_engine #(
    parameter int TABLE_DEPTH = rtit_pkg::DEF_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  rtit_pkg::t_op                 i_op,
    input  rtit_pkg::t_rec                i_rec,
    input  logic [rtit_pkg::SLOT_W-1:0]   i_read_slot,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output rtit_pkg::t_res                o_res
);
    import rtit_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int WW = AW + SLOT_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_RDWAIT = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    logic [AW-1:0]          r_idx, n_idx;
    logic                   r_found, n_found;
    logic [AW-1:0]          r_pos, n_pos;
    t_rec                   r_rec, n_rec;
    t_rec                   r_carry, n_carry;
    t_res                   r_res, n_res;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic                   r_rd_vld, n_rd_vld;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_rec          ram_wdata;
    logic [REC_W-1:0] ram_rdata;

    t_rec          rd_data;
    logic          hit;
    logic          last;
    logic [AW-1:0] idx_next;
    logic [WW-1:0] rs_wide;
    logic          rs_ok;
    logic [AW-1:0] rs_idx;
    logic [WW-1:0] pos_wide;
    logic          req_fire;

    rtit_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_req_ready = (r_state == S_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    // entries never written since the last clear read as empty
    assign rd_data  = r_rd_vld ? t_rec'(ram_rdata) : '0;
    assign hit      = (rd_data.secs == '0) || (r_rec.score > rd_data.score) ||
                      ((r_rec.score == rd_data.score) && (r_rec.secs < rd_data.secs));
    assign last     = (r_idx == AW'(TABLE_DEPTH - 1));
    assign idx_next = r_idx + AW'(1);
    assign rs_wide  = WW'(i_read_slot);
    assign rs_ok    = rs_wide < WW'(TABLE_DEPTH);
    assign rs_idx   = rs_wide[AW-1:0];

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_found   = r_found;
        n_pos     = r_pos;
        n_rec     = r_rec;
        n_carry   = r_carry;
        n_res     = r_res;
        n_valid   = r_valid;
        n_rd_vld  = r_rd_vld;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = r_carry;
        ram_re    = 1'b0;
        ram_raddr = idx_next;
        pos_wide  = WW'(r_pos);
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_res = '0;
                    case (i_op)
                        OP_INSERT: begin
                            n_rec     = i_rec;
                            n_idx     = '0;
                            n_found   = 1'b0;
                            n_pos     = '0;
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_rd_vld  = r_valid[0];
                            n_state   = S_SCAN;
                        end
                        OP_CLEAR: begin
                            n_valid = '0;
                            n_state = S_DONE;
                        end
                        OP_READ: begin
                            ram_re    = 1'b1;
                            ram_raddr = rs_idx;
                            n_rd_vld  = rs_ok && r_valid[rs_idx];
                            n_state   = S_RDWAIT;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // one slot per cycle: write this slot while the next one is read
                n_carry = rd_data;
                if (r_found) begin
                    ram_we           = 1'b1;
                    ram_wdata        = r_carry;
                    n_valid[r_idx]   = 1'b1;
                end else if (hit) begin
                    ram_we           = 1'b1;
                    ram_wdata        = r_rec;
                    n_valid[r_idx]   = 1'b1;
                    n_found          = 1'b1;
                    n_pos            = r_idx;
                end
                if (last) begin
                    pos_wide         = WW'(n_pos);
                    n_res.placed     = n_found;
                    n_res.place_slot = n_found ? pos_wide[SLOT_W-1:0] : '0;
                    n_state          = S_DONE;
                end else begin
                    ram_re   = 1'b1;
                    ram_raddr = idx_next;
                    n_rd_vld = r_valid[idx_next];
                    n_idx    = idx_next;
                end
            end
            S_RDWAIT: begin
                n_res.entry = rd_data;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_found  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_found  <= n_found;
            r_rd_vld <= n_rd_vld;
        end
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_rec   <= n_rec;
        r_carry <= n_carry;
        r_res   <= n_res;
    end

    a_found_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_found && !last) |=> (r_found && r_state == S_SCAN))
        else $error("found flag lost during carry shift");

    a_write_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SCAN))
        else $error("table write outside insert scan");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && i_op == OP_CLEAR) |=> (r_valid == '0 && r_state == S_DONE))
        else $error("clear left valid entries");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_pos <= r_idx && r_pos < AW'(TABLE_DEPTH - 1) + AW'(1) - AW'(1)
                     + AW'(1) - AW'(1) || r_pos == AW'(TABLE_DEPTH - 1)))
        else $error("insert position beyond table");

    a_not_placed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_res.placed) |-> (r_res.place_slot == '0))
        else $error("slot reported for record that did not place");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// stream-level testbench for the ranked top-n insert table with a shadow ranking table
module tb_top;

    import rtit_pkg::*;

    localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
    // an insert holds the sequencer while it scans all TABLE_DEPTH entries
    localparam int SETTLE_CYCLES = 4 * (TABLE_DEPTH + 2);
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_REQS   = 925;
    // request counts where the idle pattern changes
    localparam int PHASE1_START  = 320;
    localparam int PHASE2_START  = 640;
    // receiver hold-off that backs the block up
    localparam int HOLD_AT       = 700;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        t_op                 op;
        logic signed [31:0]  score;
        logic [SECS_W-1:0]   secs;
        logic [TAG_W-1:0]    tag;
        logic [SLOT_W-1:0]   slot;
    } t_rank_req;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    // stimulus waiting to be offered, and outcomes waiting to come back
    t_rank_req request_q[$];
    t_res      outcome_q[$];

    // shadow copy of the ranking table, empty after reset
    t_rec shadow_tbl [TABLE_DEPTH] = '{default: '0};

    int issued_cnt   = 0;
    int accepted_cnt = 0;
    int fail_cnt     = 0;
    int cycle_cnt    = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    ranked_topn_insert_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // new_score[31:0], new_time[47:32], new_tag[79:48], read_slot[82:80], zero pad
        .s_axis_tdata  (s_axis_tdata),
        // opcode[1:0]
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // place_slot[2:0], entry_score[34:3], entry_time[50:35], entry_tag[82:51], zero pad
        .m_axis_tdata  (m_axis_tdata),
        // placed[0]
        .m_axis_tuser  (m_axis_tuser)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // applies one request to the shadow table and returns the result it gives
    function automatic t_res apply_table_op(input t_op op, input logic signed [31:0] score,
                                            input logic [SECS_W-1:0] secs,
                                            input logic [TAG_W-1:0] tag,
                                            input logic [SLOT_W-1:0] slot);
        t_res res;
        int   pos;
        res = '0;
        pos = TABLE_DEPTH;
        case (op)
            OP_INSERT: begin
                // first slot that is empty, lower score, or same score with longer time
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (pos == TABLE_DEPTH &&
                        (shadow_tbl[i].secs == '0 ||
                         score > $signed(shadow_tbl[i].score) ||
                         (score == $signed(shadow_tbl[i].score) &&
                          secs < shadow_tbl[i].secs)))
                        pos = i;
                end
                if (pos < TABLE_DEPTH) begin
                    // entries below move down, the last one drops out
                    for (int i = TABLE_DEPTH - 1; i > pos; i--)
                        shadow_tbl[i] = shadow_tbl[i-1];
                    shadow_tbl[pos].score = score;
                    shadow_tbl[pos].secs  = secs;
                    shadow_tbl[pos].tag   = tag;
                    res.placed     = 1'b1;
                    res.place_slot = pos[SLOT_W-1:0];
                end
            end
            OP_CLEAR: begin
                foreach (shadow_tbl[i])
                    shadow_tbl[i] = '0;
            end
            OP_READ: begin
                // slots past the table read back as zeros
                if (int'(slot) < TABLE_DEPTH)
                    res.entry = shadow_tbl[slot];
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_cnt++;
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, field, got, want);
    endtask

    task automatic queue_req(input t_op op, input logic signed [31:0] score,
                             input logic [SECS_W-1:0] secs, input logic [TAG_W-1:0] tag,
                             input logic [SLOT_W-1:0] slot);
        t_rank_req req;
        req.op    = op;
        req.score = score;
        req.secs  = secs;
        req.tag   = tag;
        req.slot  = slot;
        request_q.push_back(req);
    endtask

    // global watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("ranked_topn_insert_table test failed");
            $finish;
        end
    end

    // long receiver hold-off once traffic runs without idles, so the block backs up
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // request driver: a new request only once the previous one was taken
    always @(negedge i_clk) begin
        int        tx_idle_pct;
        t_rank_req req;
        tx_idle_pct = (issued_cnt < PHASE1_START) ? 31 : (issued_cnt < PHASE2_START) ? 81 : 0;
        if (i_rst_n && issued_cnt == accepted_cnt) begin
            if (request_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                req = request_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= req.op;
                s_axis_tdata  <= {5'b0, req.slot, req.tag, req.secs, req.score};
                issued_cnt++;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: ready pattern follows the same phases, mirrored
    always @(negedge i_clk) begin
        int rx_idle_pct;
        rx_idle_pct = (issued_cnt < PHASE1_START) ? 81 : (issued_cnt < PHASE2_START) ? 31 : 0;
        m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // monitor: predicts on every accepted request, checks every accepted result
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                outcome_q.push_back(apply_table_op(t_op'(s_axis_tuser), s_axis_tdata[31:0],
                                                   s_axis_tdata[47:32], s_axis_tdata[79:48],
                                                   s_axis_tdata[82:80]));
                accepted_cnt++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
                end else begin
                    want = outcome_q.pop_front();
                    if (m_axis_tuser !== want.placed)
                        report_mismatch("placed", m_axis_tuser, want.placed);
                    if (m_axis_tdata[2:0] !== want.place_slot)
                        report_mismatch("place_slot", m_axis_tdata[2:0], want.place_slot);
                    if (m_axis_tdata[34:3] !== want.entry.score)
                        report_mismatch("entry_score", m_axis_tdata[34:3], want.entry.score);
                    if (m_axis_tdata[50:35] !== want.entry.secs)
                        report_mismatch("entry_time", m_axis_tdata[50:35], want.entry.secs);
                    if (m_axis_tdata[82:51] !== want.entry.tag)
                        report_mismatch("entry_tag", m_axis_tdata[82:51], want.entry.tag);
                end
            end
        end
    end

    initial begin
        t_rank_req          req;
        int                 r;
        logic signed [31:0] sc;

        // directed: empty read, score extremes, tie breaks, zero time, full table
        queue_req(OP_READ,   32'sd0,        16'd0,     32'h0,        3'd0);
        queue_req(OP_INSERT, 32'sd0,        16'd100,   32'h0,        3'd0);
        queue_req(OP_INSERT, 32'sh7fffffff, 16'hffff,  32'hffffffff, 3'd7);
        queue_req(OP_INSERT, 32'sh80000000, 16'd1,     32'ha5a5a5a5, 3'd0);
        // same score, shorter time ranks ahead
        queue_req(OP_INSERT, 32'sd0,        16'd50,    32'h11111111, 3'd0);
        // same score, longer time ranks behind
        queue_req(OP_INSERT, 32'sd0,        16'd200,   32'h22222222, 3'd0);
        // zero time places, then counts as an empty slot
        queue_req(OP_INSERT, 32'sd0,        16'd0,     32'h33333333, 3'd0);
        queue_req(OP_INSERT, -32'sd1,       16'd7,     32'h44444444, 3'd0);
        for (int i = 5; i >= 1; i--)
            queue_req(OP_INSERT, 32'(i), 16'd9, 32'(i), 3'd0);
        // lowest score with longest time never places in a full table
        queue_req(OP_INSERT, 32'sh80000000, 16'hffff,  32'h5a5a5a5a, 3'd0);
        for (int i = 0; i < TABLE_DEPTH; i++)
            queue_req(OP_READ, 32'sd0, 16'd0, 32'h0, 3'(i));
        queue_req(OP_NOP,    32'sh7fffffff, 16'hffff,  32'hffffffff, 3'd7);
        queue_req(OP_CLEAR,  32'sd0,        16'd0,     32'h0,        3'd0);
        queue_req(OP_READ,   32'sd0,        16'd0,     32'h0,        3'd3);

        // random: mostly inserts with many ties, reads of every slot, rare clears
        for (int n = 0; n < RANDOM_REQS; n++) begin
            r = $urandom_range(0, 99);
            req.op = (r < 66) ? OP_INSERT : (r < 91) ? OP_READ : (r < 94) ? OP_CLEAR : OP_NOP;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: sc = int'($urandom_range(0, 8)) - 4;
                4, 5, 6:    sc = $urandom;
                7: begin
                    case ($urandom_range(0, 3))
                        0:       sc = 32'sh7fffffff;
                        1:       sc = 32'sh80000000;
                        2:       sc = 32'sd0;
                        default: sc = -32'sd1;
                    endcase
                end
                default:    sc = int'($urandom_range(0, 40)) - 20;
            endcase
            req.score = sc;
            r = $urandom_range(0, 99);
            if (r < 10)
                req.secs = '0;
            else if (r < 60)
                req.secs = SECS_W'($urandom_range(1, 6));
            else if (r < 70)
                req.secs = '1;
            else
                req.secs = SECS_W'($urandom_range(0, 65535));
            req.tag  = $urandom;
            req.slot = SLOT_W'($urandom_range(0, 7));
            request_q.push_back(req);
        end

        // single reset at the start
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all requests taken, all results back, then let the sequencer settle
        while (request_q.size() != 0 || issued_cnt != accepted_cnt || outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("ranked_topn_insert_table test passed");
        else
            $display("ranked_topn_insert_table test failed");
        $finish;
    end

endmodule
